>>> hdl/sgm_pkg.sv
// Shared constants and types for the Scharr gradient magnitude core.
package sgm_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int DIM_W          = 13;
    localparam int ROW_W          = 12;
    localparam int COL_W          = 10;
    localparam int CFG_WIDTH_W    = 11;
    localparam int CFG_HEIGHT_W   = 13;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int OUT_DATA_W     = 48;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // metadata that travels beside a result through the pipe
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       grad_x;
        logic [7:0]       grad_y;
        logic             last;
        logic             sat;
    } t_sgm_side;

endpackage

>>> hdl/scharr_gradient_magnitude_core.sv
// Scharr gradient magnitude core: top level with counters, squaring and ports.
//
// Takes an 8-bit grayscale frame in raster order, one pixel per request on the
// s_axis side, and returns one result per interior pixel on the m_axis side:
// row, column, |Gx| and |Gy| of the 3x3 Scharr kernels (each clipped to 255)
// and floor(sqrt(gx^2 + gy^2)) of the clipped values, clipped to 255. The
// last interior pixel of a frame carries tlast; border pixels give nothing.
// Throughput is one pixel per clock while m_axis does not hold off. The pipe
// is: line store read (synchronous RAM) with the kernel and write-back,
// clipped-gradient register, two squarers, then eight square-root digit
// stages, the last of which drives m_axis directly.
// Back-pressure on m_axis stalls the whole pipe, so s_axis_tready follows it.
// Line store entries are never cleared; the first two rows of a frame only
// fill them. Image width and height sit at APB offsets 0x0 and 0x4; a write
// to either restarts the frame (counters and window cleared). Values outside
// [3, MaxWidth] and [3, 4096] are clipped when used. Write them only while
// the core is idle.
module scharr_gradient_magnitude_core #(
    parameter int  MaxWidth = sgm_pkg::MAX_WIDTH,
    localparam int AW       = $clog2(MaxWidth)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sgm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sgm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sgm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // pixel stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [11:0] out_row, [21:12] out_col, [29:22] gradient_x,
    // [37:30] gradient_y, [45:38] grad_magnitude, [47:46] zero
    output logic [sgm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast    // frame_last
);

    localparam logic [sgm_pkg::DIM_W-1:0] MaxW = sgm_pkg::DIM_W'(MaxWidth);
    localparam logic [sgm_pkg::DIM_W-1:0] MaxH = sgm_pkg::DIM_W'(sgm_pkg::MAX_HEIGHT);

    // configuration
    logic [sgm_pkg::CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [sgm_pkg::CFG_HEIGHT_W-1:0] r_cfg_height;
    logic                             cfg_wr;
    logic [sgm_pkg::DIM_W-1:0]        eff_w, eff_h, cfg_w_ext;

    // position of the next incoming pixel
    logic [AW-1:0]               r_col;
    logic [sgm_pkg::ROW_W-1:0]   r_row;
    logic [sgm_pkg::DIM_W-1:0]   col_ext, row_ext, col_m1, row_m1;
    logic                        col_end, row_end;

    // pipe control
    logic adv, accept;

    // stage 1: beside the line store read
    logic               r_s1_prod;
    sgm_pkg::t_sgm_side r_s1_side;
    sgm_pkg::t_sgm_side s1_side_in;
    logic [7:0]         grad_x, grad_y;

    // stage 2: clipped gradients
    logic               r_s2_valid;
    sgm_pkg::t_sgm_side r_s2_side;
    sgm_pkg::t_sgm_side s2_side_in;

    // stage 3: squares
    logic               r_s3_valid;
    logic [15:0]        r_sq_x, r_sq_y;
    sgm_pkg::t_sgm_side r_s3_side;
    logic [16:0]        sq_sum;
    sgm_pkg::t_sgm_side s3_side_sat;

    // square root result, doubles as output register
    logic               rt_valid;
    logic [7:0]         rt_root;
    sgm_pkg::t_sgm_side rt_side;
    logic [7:0]         mag;
    logic [sgm_pkg::DIM_W-1:0] last_col, last_row;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= sgm_pkg::WIDTH_RESET;
            r_cfg_height <= sgm_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                sgm_pkg::REG_IMAGE_WIDTH:  r_cfg_width  <= pwdata[sgm_pkg::CFG_WIDTH_W-1:0];
                sgm_pkg::REG_IMAGE_HEIGHT: r_cfg_height <= pwdata[sgm_pkg::CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sgm_pkg::REG_IMAGE_WIDTH:
                prdata = sgm_pkg::APB_DATA_W'(r_cfg_width);
            sgm_pkg::REG_IMAGE_HEIGHT:
                prdata = sgm_pkg::APB_DATA_W'(r_cfg_height);
            default:
                prdata = '0;
        endcase
    end

    // clip to the supported frame size
    always_comb begin
        cfg_w_ext = sgm_pkg::DIM_W'(r_cfg_width);
        if (cfg_w_ext < 13'd3)   eff_w = 13'd3;
        else if (cfg_w_ext > MaxW) eff_w = MaxW;
        else                     eff_w = cfg_w_ext;
        if (r_cfg_height < 13'd3)  eff_h = 13'd3;
        else if (r_cfg_height > MaxH) eff_h = MaxH;
        else                     eff_h = r_cfg_height;
    end

    // ---------------------------------------------------------------- counters
    // whole pipe moves when the output register is empty or being taken
    assign adv           = !rt_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    always_comb begin
        col_ext = sgm_pkg::DIM_W'(r_col);
        row_ext = sgm_pkg::DIM_W'(r_row);
        col_m1  = col_ext - 13'd1;
        row_m1  = row_ext - 13'd1;
        col_end = (col_ext + 13'd1) >= eff_w;
        row_end = (row_ext + 13'd1) >= eff_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- line stores
    sgm_window #(
        .MaxWidth (MaxWidth)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_clear     (cfg_wr),
        .i_req_valid (accept),
        .i_pixel     (s_axis_tdata),
        .i_col       (r_col),
        .o_grad_x    (grad_x),
        .o_grad_y    (grad_y)
    );

    // ---------------------------------------------------------------- stages 1..3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_prod  <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            // interior once two rows and two columns are behind the pixel
            r_s1_prod  <= accept && (r_row >= 12'd2) && (col_ext >= 13'd2);
            r_s2_valid <= r_s1_prod;
            r_s3_valid <= r_s2_valid;
        end
    end

    // side data for the next stage 1 and 2 contents
    always_comb begin
        s1_side_in        = '0;
        s1_side_in.row    = row_m1[sgm_pkg::ROW_W-1:0];
        s1_side_in.col    = col_m1[sgm_pkg::COL_W-1:0];
        s1_side_in.last   = col_end && row_end;

        s2_side_in        = r_s1_side;
        s2_side_in.grad_x = grad_x;
        s2_side_in.grad_y = grad_y;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_side <= s1_side_in;
            r_s2_side <= s2_side_in;

            r_sq_x    <= r_s2_side.grad_x * r_s2_side.grad_x;
            r_sq_y    <= r_s2_side.grad_y * r_s2_side.grad_y;
            r_s3_side <= r_s2_side;
        end
    end

    // sums at or above 2^16 have a root of at least 256: clip
    always_comb begin
        sq_sum          = {1'b0, r_sq_x} + {1'b0, r_sq_y};
        s3_side_sat     = r_s3_side;
        s3_side_sat.sat = sq_sum[16];
    end

    sgm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_s3_valid),
        .i_value (sq_sum[15:0]),
        .i_side  (s3_side_sat),
        .o_valid (rt_valid),
        .o_root  (rt_root),
        .o_side  (rt_side)
    );

    // ---------------------------------------------------------------- output
    assign mag           = rt_side.sat ? 8'hFF : rt_root;
    assign m_axis_tvalid = rt_valid;
    assign m_axis_tlast  = rt_side.last;
    assign m_axis_tdata  = {2'b00, mag, rt_side.grad_y, rt_side.grad_x,
                            rt_side.col, rt_side.row};

    assign last_col = eff_w - 13'd2;
    assign last_row = eff_h - 13'd2;

    // ---------------------------------------------------------------- checks
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (col_ext < eff_w) && (row_ext < eff_h))
        else $error("pixel position outside the frame");

    a_mag_ge_parts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rt_valid |-> (mag >= rt_side.grad_x) && (mag >= rt_side.grad_y))
        else $error("magnitude below one of its gradients");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rt_valid && rt_side.last) |->
            (rt_side.col == last_col[sgm_pkg::COL_W-1:0]) &&
            (rt_side.row == last_row[sgm_pkg::ROW_W-1:0]))
        else $error("frame end flagged away from the last interior pixel");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && !adv) |=> r_s3_valid)
        else $error("pipe stage lost an item during a stall");

endmodule

>>> hdl/sgm_window.sv
// Line stores, 3x3 window and Scharr kernels.
module sgm_window #(
    parameter int  MaxWidth = sgm_pkg::MAX_WIDTH,
    localparam int AW       = $clog2(MaxWidth)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_clear,
    input  logic          i_req_valid,
    input  logic [7:0]    i_pixel,
    input  logic [AW-1:0] i_col,
    output logic [7:0]    o_grad_x,
    output logic [7:0]    o_grad_y
);

    logic [7:0]    r_mem_upper  [MaxWidth];
    logic [7:0]    r_mem_middle [MaxWidth];
    logic [7:0]    r_top;
    logic [7:0]    r_mid;
    logic          r_s1_valid;
    logic [7:0]    r_s1_px;
    logic [AW-1:0] r_s1_col;
    logic [7:0]    r_win [6];

    logic signed [13:0] a00, a10, a20, a01, a21, a02, a12, a22;
    logic signed [13:0] gx, gy;
    logic [13:0]        mx, my;

    // read at request, write back on the next advance; same column recurs >= 3 items apart
    always_ff @(posedge i_clk) begin
        if (i_adv && i_req_valid) begin
            r_top <= r_mem_upper[i_col];
            r_mid <= r_mem_middle[i_col];
        end
        if (i_adv && r_s1_valid) begin
            r_mem_upper[r_s1_col]  <= r_mid;
            r_mem_middle[r_s1_col] <= r_s1_px;
        end
        if (i_adv) begin
            r_s1_px  <= i_pixel;
            r_s1_col <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            for (int i = 0; i < 6; i++) r_win[i] <= 8'd0;
        end else begin
            if (i_adv) r_s1_valid <= i_req_valid;
            if (i_clear) begin
                for (int i = 0; i < 6; i++) r_win[i] <= 8'd0;
            end else if (i_adv && r_s1_valid) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= r_top;
                r_win[4] <= r_mid;
                r_win[5] <= r_s1_px;
            end
        end
    end

    always_comb begin
        a00 = $signed({6'd0, r_win[0]});
        a10 = $signed({6'd0, r_win[1]});
        a20 = $signed({6'd0, r_win[2]});
        a01 = $signed({6'd0, r_win[3]});
        a21 = $signed({6'd0, r_win[5]});
        a02 = $signed({6'd0, r_top});
        a12 = $signed({6'd0, r_mid});
        a22 = $signed({6'd0, r_s1_px});
        gx  = 14'sd3 * (a02 - a00) + 14'sd10 * (a12 - a10) + 14'sd3 * (a22 - a20);
        gy  = 14'sd3 * (a20 - a00) + 14'sd10 * (a21 - a01) + 14'sd3 * (a22 - a02);
        mx  = gx[13] ? 14'(-gx) : 14'(gx);
        my  = gy[13] ? 14'(-gy) : 14'(gy);
        o_grad_x = (|mx[13:8]) ? 8'hFF : mx[7:0];
        o_grad_y = (|my[13:8]) ? 8'hFF : my[7:0];
    end

endmodule

>>> hdl/sgm_isqrt.sv
// Pipelined floor square root of a 16-bit value, one result bit per stage.
module sgm_isqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [15:0]       i_value,
    input  sgm_pkg::t_sgm_side i_side,
    output logic              o_valid,
    output logic [7:0]        o_root,
    output sgm_pkg::t_sgm_side o_side
);

    localparam int Steps = 8;

    typedef struct packed {
        logic [8:0]  rem;
        logic [7:0]  root;
        logic [15:0] val;
    } t_sq_state;

    t_sq_state          r_st   [Steps];
    t_sq_state          n_st   [Steps];
    sgm_pkg::t_sgm_side r_side [Steps];
    logic [Steps-1:0]   r_vld;

    // restoring digit step: bring down two bits, try (4*root + 1)
    function automatic t_sq_state sq_step(input t_sq_state s);
        logic [10:0] t_rem;
        logic [10:0] trial;
        t_sq_state   o;
        t_rem = {s.rem, s.val[15:14]};
        trial = {1'b0, s.root, 2'b01};
        o.val = {s.val[13:0], 2'b00};
        if (t_rem >= trial) begin
            o.rem  = 9'(t_rem - trial);
            o.root = {s.root[6:0], 1'b1};
        end else begin
            o.rem  = t_rem[8:0];
            o.root = {s.root[6:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        n_st[0] = sq_step(t_sq_state'{rem: 9'd0, root: 8'd0, val: i_value});
        for (int i = 1; i < Steps; i++) n_st[i] = sq_step(r_st[i-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[Steps-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= i_side;
            for (int i = 0; i < Steps; i++) r_st[i] <= n_st[i];
            for (int i = 1; i < Steps; i++) r_side[i] <= r_side[i-1];
        end
    end

    assign o_valid = r_vld[Steps-1];
    assign o_root  = r_st[Steps-1].root;
    assign o_side  = r_side[Steps-1];

endmodule
